// ----- design/whp_pkg.sv -----
`default_nettype none

package whp_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  out_byte;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		logic [28:0] frame_bytes;
		logic [31:0] data_length;
		logic [31:0] frame_index;
		logic        block_mismatch;
		logic        end_of_stream;
		logic [2:0]  error_code;
	} out_word_t;

	typedef enum logic [4:0] {
		PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_CODE, PH_CHAN,
		PH_RATE, PH_BRATE, PH_BLOCK, PH_BITS, PH_CBSZ, PH_VALID, PH_MASK,
		PH_SUBF, PH_SKIP, PH_DTAG, PH_DLEN, PH_AUDIO
	} phase_t;

	localparam logic [1:0] KIND_HDR   = 2'd0;
	localparam logic [1:0] KIND_AUDIO = 2'd1;
	localparam logic [1:0] KIND_READY = 2'd2;
	localparam logic [1:0] KIND_ERR   = 2'd3;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_RIFF  = 3'd1;
	localparam logic [2:0] ERR_FMT   = 3'd2;
	localparam logic [2:0] ERR_CODE  = 3'd3;
	localparam logic [2:0] ERR_DATA  = 3'd4;
	localparam logic [2:0] ERR_TRUNC = 3'd5;

	localparam logic [15:0] FMT_PCM = 16'h0001;
	localparam logic [15:0] FMT_EXT = 16'hFFFE;
	localparam logic [31:0] BASIC_FMT_LEN = 32'd16;
	localparam logic [31:0] EXT_FMT_LEN   = 32'd10;

	function automatic logic [2:0] phase_len(input phase_t ph);
		logic [2:0] len;
		unique case (ph)
			PH_CODE, PH_CHAN, PH_BLOCK, PH_BITS, PH_CBSZ, PH_VALID, PH_SUBF: len = 3'd2;
			PH_SKIP, PH_AUDIO: len = 3'd1;
			default: len = 3'd4;
		endcase
		return len;
	endfunction

	function automatic logic is_tag(input phase_t ph);
		return (ph == PH_RIFF) || (ph == PH_WAVE) || (ph == PH_FMT) || (ph == PH_DTAG);
	endfunction

	function automatic logic [7:0] tag_char(input phase_t ph, input logic [1:0] n);
		logic [31:0] tag;
		unique case (ph)
			PH_RIFF: tag = {"F", "F", "I", "R"};
			PH_WAVE: tag = {"E", "V", "A", "W"};
			PH_FMT:  tag = {" ", "t", "m", "f"};
			default: tag = {"a", "t", "a", "d"};
		endcase
		return tag[{n, 3'b000} +: 8];
	endfunction

	function automatic logic [2:0] tag_err(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_DTAG: code = ERR_DATA;
			PH_FMT:  code = ERR_FMT;
			default: code = ERR_RIFF;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- design/whp_in_reg.sv -----
`default_nettype none

module whp_in_reg
	import whp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_stall,
	input  wire in_word_t src_word,
	input  wire logic     advance,
	output logic          s1_valid,
	output in_word_t      s1_word
);

	logic     valid_s1;
	in_word_t word_s1;

	assign src_stall = valid_s1 & ~advance;
	assign s1_valid  = valid_s1;
	assign s1_word   = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_word;
		end
	end

endmodule

`default_nettype wire

// ----- design/whp_core.sv -----
`default_nettype none

module whp_core
	import whp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire in_word_t item,
	output out_word_t     result
);

	phase_t      phase_q, phase_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [31:0] shift_q, shift_d, shift_v;
	logic [31:0] skip_q, skip_d, skip_t;
	logic        ext_q, ext_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] cont_q, cont_d;
	logic [15:0] vbits_q, vbits_d;
	logic [15:0] block_q, block_d;
	logic [31:0] dlen_q, dlen_d;
	logic [28:0] bif_q, bif_d;
	logic [31:0] fcnt_q, fcnt_d;
	logic [2:0]  err_q, err_d;
	logic [28:0] fb_q, fb_d;
	logic [1:0]  kind;
	logic [7:0]  obyte;
	logic [31:0] fidx;

	assign fb_d = {13'd0, chan_d} * {16'd0, cont_d[15:3]};

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		skip_d  = skip_q;
		ext_d   = ext_q;
		chan_d  = chan_q;
		rate_d  = rate_q;
		cont_d  = cont_q;
		vbits_d = vbits_q;
		block_d = block_q;
		dlen_d  = dlen_q;
		bif_d   = bif_q;
		fcnt_d  = fcnt_q;
		err_d   = err_q;
		kind    = KIND_HDR;
		obyte   = 8'd0;
		fidx    = 32'd0;
		shift_v = shift_q | ({24'd0, item.in_byte} << {cnt_q, 3'b000});
		skip_t  = 32'd0;
		if (err_q != ERR_NONE) begin
			kind = KIND_ERR;
		end else if (phase_q == PH_AUDIO) begin
			kind  = KIND_AUDIO;
			obyte = item.in_byte;
			fidx  = fcnt_q;
			if (fb_q == 29'd0 || ({1'b0, bif_q} + 30'd1) >= {1'b0, fb_q}) begin
				bif_d  = 29'd0;
				fcnt_d = fcnt_q + 32'd1;
			end else begin
				bif_d = bif_q + 29'd1;
			end
		end else if (phase_q == PH_SKIP) begin
			skip_d = (skip_q > 32'd1) ? skip_q - 32'd1 : 32'd0;
			if (skip_q <= 32'd1) begin
				phase_d = PH_DTAG;
			end
		end else if (phase_q > PH_AUDIO) begin
			phase_d = PH_RIFF;
		end else if (is_tag(phase_q) && tag_char(phase_q, cnt_q) != item.in_byte) begin
			err_d = tag_err(phase_q);
		end else if (({1'b0, cnt_q} + 3'd1) >= phase_len(phase_q)) begin
			cnt_d   = 2'd0;
			shift_d = 32'd0;
			unique case (phase_q)
				PH_FSIZE: begin
					skip_d  = shift_v;
					phase_d = PH_CODE;
				end
				PH_CODE: begin
					if (shift_v[15:0] == FMT_PCM) begin
						ext_d   = 1'b0;
						phase_d = PH_CHAN;
					end else if (shift_v[15:0] == FMT_EXT) begin
						ext_d   = 1'b1;
						phase_d = PH_CHAN;
					end else begin
						err_d = ERR_CODE;
					end
				end
				PH_CHAN: begin
					chan_d  = shift_v[15:0];
					phase_d = PH_RATE;
				end
				PH_RATE: begin
					rate_d  = shift_v;
					phase_d = PH_BRATE;
				end
				PH_BLOCK: begin
					block_d = shift_v[15:0];
					phase_d = PH_BITS;
				end
				PH_BITS: begin
					cont_d = shift_v[15:0];
					skip_t = (skip_q > BASIC_FMT_LEN) ? skip_q - BASIC_FMT_LEN : 32'd0;
					skip_d = skip_t;
					if (ext_q) begin
						phase_d = PH_CBSZ;
					end else begin
						phase_d = (skip_t != 32'd0) ? PH_SKIP : PH_DTAG;
					end
				end
				PH_VALID: begin
					vbits_d = shift_v[15:0];
					phase_d = PH_MASK;
				end
				PH_SUBF: begin
					skip_t  = (skip_q > EXT_FMT_LEN) ? skip_q - EXT_FMT_LEN : 32'd0;
					skip_d  = skip_t;
					phase_d = (skip_t != 32'd0) ? PH_SKIP : PH_DTAG;
				end
				PH_DLEN: begin
					dlen_d  = shift_v;
					bif_d   = 29'd0;
					fcnt_d  = 32'd0;
					phase_d = PH_AUDIO;
					kind    = KIND_READY;
				end
				default: begin
					phase_d = phase_t'(phase_q + 5'd1);
				end
			endcase
		end else begin
			cnt_d   = cnt_q + 2'd1;
			shift_d = shift_v;
		end
		if (kind == KIND_HDR && err_d == ERR_NONE && item.last_byte) begin
			err_d = ERR_TRUNC;
		end
		if (kind == KIND_HDR && err_d != ERR_NONE) begin
			kind = KIND_ERR;
		end
	end

	always_comb begin
		result.out_kind       = kind;
		result.out_byte       = obyte;
		result.channel_count  = chan_d;
		result.sample_rate    = rate_d;
		result.sample_bits    = ext_d ? vbits_d : cont_d;
		result.frame_bytes    = fb_d;
		result.data_length    = dlen_d;
		result.frame_index    = fidx;
		result.block_mismatch = ({13'd0, block_d} != fb_d);
		result.end_of_stream  = item.last_byte;
		result.error_code     = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			cnt_q   <= 2'd0;
			shift_q <= 32'd0;
			skip_q  <= 32'd0;
			ext_q   <= 1'b0;
			chan_q  <= 16'd0;
			rate_q  <= 32'd0;
			cont_q  <= 16'd0;
			vbits_q <= 16'd0;
			block_q <= 16'd0;
			dlen_q  <= 32'd0;
			bif_q   <= 29'd0;
			fcnt_q  <= 32'd0;
			err_q   <= ERR_NONE;
			fb_q    <= 29'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			skip_q  <= skip_d;
			ext_q   <= ext_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			cont_q  <= cont_d;
			vbits_q <= vbits_d;
			block_q <= block_d;
			dlen_q  <= dlen_d;
			bif_q   <= bif_d;
			fcnt_q  <= fcnt_d;
			err_q   <= err_d;
			fb_q    <= fb_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/wav_header_parser_top.sv -----
// channel  signals                          word
// src      src_valid / src_stall (in)       in_word_t:  byte, last flag
// dst      dst_valid / dst_stall (out)      out_word_t: kind, audio byte, format, status
//
// One byte per cycle sustained while dst_stall is low; each accepted byte yields one result word.
// An accepted byte passes through the input register and then the result register.
// The parse step sits between the input register and the result register.
// Reset restarts the parse at the RIFF tag and clears any sticky error.
// dst_stall holds the result; the input register still takes one more byte if it is empty.
`default_nettype none

module wav_header_parser_top
	import whp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_stall,
	input  wire in_word_t  src_word,
	output logic           dst_valid,
	input  wire logic      dst_stall,
	output out_word_t      dst_word
);

	logic      advance;
	logic      fire;
	logic      s1_valid;
	in_word_t  s1_word;
	out_word_t result;
	logic      dst_valid_q;
	out_word_t dst_word_q;

	assign advance   = ~dst_valid_q | ~dst_stall;
	assign fire      = s1_valid & advance;
	assign dst_valid = dst_valid_q;
	assign dst_word  = dst_word_q;

	whp_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.advance   (advance),
		.s1_valid  (s1_valid),
		.s1_word   (s1_word)
	);

	whp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (s1_word),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (advance) begin
			dst_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dst_word_q <= result;
		end
	end

	a_audio_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.out_kind == KIND_AUDIO |-> dst_word.error_code == ERR_NONE)
		else $error("audio word carries an error code");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.out_kind == KIND_ERR |-> dst_word.error_code != ERR_NONE)
		else $error("error word without error code");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid)
		else $error("input register dropped a byte");

endmodule

`default_nettype wire

// ----- bench/wav_header_parser_checker.sv -----
`default_nettype none

module wav_header_parser_checker
	import whp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	input  wire logic      src_stall,
	input  wire in_word_t  src_word,
	input  wire logic      dst_valid,
	input  wire logic      dst_stall,
	input  wire out_word_t dst_word,
	output int             mismatches,
	output int             outstanding
);

	phase_t      phase;
	logic [2:0]  nbytes;
	logic [31:0] acc;
	logic [31:0] skip_left;
	logic        ext_fmt;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [15:0] cont_bits;
	logic [15:0] valid_bits;
	logic [15:0] blk_align;
	logic [31:0] data_len;
	logic [28:0] frame_pos;
	logic [31:0] frame_num;
	logic [2:0]  err;
	out_word_t   expected_q[$];

	function automatic int field_len(input phase_t ph);
		case (ph)
			PH_CODE, PH_CHAN, PH_BLOCK, PH_BITS, PH_CBSZ, PH_VALID, PH_SUBF: return 2;
			default: return 4;
		endcase
	endfunction

	function automatic logic [28:0] frame_size();
		logic [31:0] p;
		p = {16'd0, chans} * {19'd0, cont_bits[15:3]};
		return p[28:0];
	endfunction

	function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a - b : 32'd0;
	endfunction

	function automatic void enter_data_or_skip();
		phase = (skip_left != 0) ? PH_SKIP : PH_DTAG;
	endfunction

	// returns 1 when the data length completes the header
	function automatic bit close_field(input logic [31:0] v);
		case (phase)
			PH_FSIZE: begin
				skip_left = v;
				phase = PH_CODE;
			end
			PH_CODE: begin
				if (v == {16'd0, FMT_PCM}) begin
					ext_fmt = 1'b0;
					phase = PH_CHAN;
				end else if (v == {16'd0, FMT_EXT}) begin
					ext_fmt = 1'b1;
					phase = PH_CHAN;
				end else begin
					err = ERR_CODE;
				end
			end
			PH_CHAN: begin
				chans = v[15:0];
				phase = PH_RATE;
			end
			PH_RATE: begin
				rate = v;
				phase = PH_BRATE;
			end
			PH_BLOCK: begin
				blk_align = v[15:0];
				phase = PH_BITS;
			end
			PH_BITS: begin
				cont_bits = v[15:0];
				skip_left = sat_sub(skip_left, BASIC_FMT_LEN);
				if (ext_fmt)
					phase = PH_CBSZ;
				else
					enter_data_or_skip();
			end
			PH_VALID: begin
				valid_bits = v[15:0];
				phase = PH_MASK;
			end
			PH_SUBF: begin
				skip_left = sat_sub(skip_left, EXT_FMT_LEN);
				enter_data_or_skip();
			end
			PH_DLEN: begin
				data_len = v;
				frame_pos = '0;
				frame_num = '0;
				phase = PH_AUDIO;
				return 1'b1;
			end
			default: phase = phase_t'(phase + 5'd1);
		endcase
		return 1'b0;
	endfunction

	function automatic out_word_t predict_word(input in_word_t w);
		out_word_t   o;
		logic [31:0] tag;
		logic [2:0]  tag_err;
		logic [28:0] fb;
		int          n;
		o = '0;
		if (err != ERR_NONE) begin
			o.out_kind = KIND_ERR;
		end else if (phase == PH_AUDIO) begin
			o.out_kind = KIND_AUDIO;
			o.out_byte = w.in_byte;
			o.frame_index = frame_num;
			fb = frame_size();
			if (fb == 0 || {3'd0, frame_pos} + 32'd1 >= {3'd0, fb}) begin
				frame_pos = '0;
				frame_num = frame_num + 32'd1;
			end else begin
				frame_pos = frame_pos + 29'd1;
			end
		end else if (phase == PH_SKIP) begin
			skip_left = sat_sub(skip_left, 32'd1);
			if (skip_left == 0)
				phase = PH_DTAG;
		end else begin
			n = int'(nbytes[1:0]);
			case (phase)
				PH_RIFF: begin tag = "RIFF"; tag_err = ERR_RIFF; end
				PH_WAVE: begin tag = "WAVE"; tag_err = ERR_RIFF; end
				PH_FMT:  begin tag = "fmt "; tag_err = ERR_FMT; end
				PH_DTAG: begin tag = "data"; tag_err = ERR_DATA; end
				default: begin tag = '0; tag_err = ERR_NONE; end
			endcase
			if (tag_err != ERR_NONE && tag[8 * (3 - n) +: 8] != w.in_byte) begin
				err = tag_err;
			end else begin
				acc = acc | ({24'd0, w.in_byte} << (8 * n));
				nbytes = 3'(n + 1);
				if (int'(nbytes) >= field_len(phase)) begin
					fb = '0;
					nbytes = '0;
					if (close_field(acc))
						o.out_kind = KIND_READY;
					acc = '0;
				end
			end
		end

		if (o.out_kind == KIND_HDR && err == ERR_NONE && w.last_byte)
			err = ERR_TRUNC;
		if (o.out_kind == KIND_HDR && err != ERR_NONE)
			o.out_kind = KIND_ERR;

		fb = frame_size();
		o.channel_count = chans;
		o.sample_rate = rate;
		o.sample_bits = ext_fmt ? valid_bits : cont_bits;
		o.frame_bytes = fb;
		o.data_length = data_len;
		o.block_mismatch = ({16'd0, blk_align} != {3'd0, fb});
		o.end_of_stream = w.last_byte;
		o.error_code = err;
		return o;
	endfunction

	function automatic int field_check(input string name, input logic [31:0] e,
		input logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		int        bad;
		if (!arst_n) begin
			phase = PH_RIFF;
			nbytes = '0;
			acc = '0;
			skip_left = '0;
			ext_fmt = 1'b0;
			chans = '0;
			rate = '0;
			cont_bits = '0;
			valid_bits = '0;
			blk_align = '0;
			data_len = '0;
			frame_pos = '0;
			frame_num = '0;
			err = ERR_NONE;
			expected_q.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (dst_valid && !dst_stall) begin
				if (expected_q.size() == 0) begin
					$error("result word %h with nothing expected", dst_word);
					bad = 1;
				end else begin
					exp_w = expected_q.pop_front();
					bad += field_check("out_kind", 32'(exp_w.out_kind),
						32'(dst_word.out_kind));
					bad += field_check("out_byte", 32'(exp_w.out_byte),
						32'(dst_word.out_byte));
					bad += field_check("channel_count", 32'(exp_w.channel_count),
						32'(dst_word.channel_count));
					bad += field_check("sample_rate", exp_w.sample_rate, dst_word.sample_rate);
					bad += field_check("sample_bits", 32'(exp_w.sample_bits),
						32'(dst_word.sample_bits));
					bad += field_check("frame_bytes", 32'(exp_w.frame_bytes),
						32'(dst_word.frame_bytes));
					bad += field_check("data_length", exp_w.data_length, dst_word.data_length);
					bad += field_check("frame_index", exp_w.frame_index, dst_word.frame_index);
					bad += field_check("block_mismatch", 32'(exp_w.block_mismatch),
						32'(dst_word.block_mismatch));
					bad += field_check("end_of_stream", 32'(exp_w.end_of_stream),
						32'(dst_word.end_of_stream));
					bad += field_check("error_code", 32'(exp_w.error_code),
						32'(dst_word.error_code));
				end
			end
			if (src_valid && !src_stall)
				expected_q.push_back(predict_word(src_word));
			outstanding <= expected_q.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

`default_nettype wire

// ----- bench/wav_header_parser_top_test.sv -----
`default_nettype none

module wav_header_parser_top_test;
	import whp_pkg::*;

	localparam int ITEMS      = 1400;
	localparam int MAX_WAIT   = 13;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN      = 8;

	typedef enum int {
		SC_CLEAN, SC_BAD_TAG, SC_BAD_CODE, SC_CUT, SC_LAST_READY
	} scenario_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_word_t  src_word = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_word_t dst_word;
	int        mismatches;
	int        outstanding;
	bit        src_calm = 1'b0;
	bit        dst_calm = 1'b0;
	in_word_t  file_q[$];

	wav_header_parser_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word)
	);

	wav_header_parser_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_word    (src_word),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.dst_word    (dst_word),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// calm stretches: no waiting at all until the next flip
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = ~calm;
		return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	task automatic push_field(input logic [31:0] v, input int n);
		in_word_t w;
		for (int i = 0; i < n; i++) begin
			w.in_byte = v[8 * i +: 8];
			w.last_byte = 1'b0;
			file_q.push_back(w);
		end
	endtask

	task automatic push_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			push_field({24'd0, t[8 * i +: 8]}, 1);
	endtask

	task automatic send_byte(input in_word_t w);
		int idle;
		idle = draw_wait(src_calm);
		if (idle > 0) begin
			src_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= w;
		do
			@(posedge clk);
		while (src_stall);
	endtask

	initial begin
		scenario_t   scen;
		bit          ext;
		logic [15:0] chans;
		logic [15:0] bits;
		logic [15:0] code;
		logic [15:0] vbits;
		logic [31:0] rate;
		logic [28:0] fb;
		logic [31:0] fsize;
		logic [31:0] skip;
		int          tag_pos[$];
		int          pick;
		in_word_t    w;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		pick = $urandom_range(0, 9);
		scen = (pick < 6) ? SC_CLEAN : scenario_t'(pick - 5);
		ext = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: chans = 16'd0;
			1: chans = 16'hFFFF;
			default: chans = 16'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 9))
			0: bits = 16'd0;
			1: bits = 16'hFFFF;
			2: bits = 16'($urandom);
			default: bits = 16'(8 * $urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 5))
			0: vbits = 16'd0;
			1: vbits = 16'hFFFF;
			default: vbits = 16'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: rate = 32'd0;
			1: rate = 32'hFFFF_FFFF;
			default: rate = $urandom;
		endcase
		fb = 29'({16'd0, chans} * {19'd0, bits[15:3]});

		// short fmt chunks leave nothing to skip
		if ($urandom_range(0, 3) == 0)
			fsize = $urandom_range(0, ext ? 25 : 15);
		else
			fsize = (ext ? 32'd26 : 32'd16) + $urandom_range(0, 6);
		skip = (fsize > 16) ? fsize - 16 : 0;
		if (ext)
			skip = (skip > 10) ? skip - 10 : 0;

		code = ext ? FMT_EXT : FMT_PCM;
		if (scen == SC_BAD_CODE) begin
			case ($urandom_range(0, 2))
				0: code = 16'h0000;
				1: code = 16'hFFFF;
				default: begin
					do
						code = 16'($urandom);
					while (code == FMT_PCM || code == FMT_EXT);
				end
			endcase
		end

		tag_pos.push_back(file_q.size());
		push_tag("RIFF");
		push_field($urandom, 4);
		tag_pos.push_back(file_q.size());
		push_tag("WAVE");
		tag_pos.push_back(file_q.size());
		push_tag("fmt ");
		push_field(fsize, 4);
		push_field({16'd0, code}, 2);
		push_field({16'd0, chans}, 2);
		push_field(rate, 4);
		push_field($urandom, 4);
		push_field(($urandom_range(0, 3) == 0) ? $urandom : {3'd0, fb}, 2);
		push_field({16'd0, bits}, 2);
		if (ext) begin
			push_field($urandom, 2);
			push_field({16'd0, vbits}, 2);
			push_field($urandom, 4);
			push_field($urandom, 2);
		end
		for (int i = 0; i < int'(skip); i++)
			push_field($urandom, 1);
		tag_pos.push_back(file_q.size());
		push_tag("data");
		push_field($urandom, 4);

		case (scen)
			SC_BAD_TAG: begin
				pick = tag_pos[$urandom_range(0, 3)] + $urandom_range(0, 3);
				w = file_q[pick];
				w.in_byte = w.in_byte ^ 8'($urandom_range(1, 255));
				w.last_byte = 1'($urandom_range(0, 1));
				file_q[pick] = w;
			end
			SC_CUT: begin
				pick = $urandom_range(0, file_q.size() - 2);
				w = file_q[pick];
				w.last_byte = 1'b1;
				file_q[pick] = w;
			end
			SC_LAST_READY: begin
				pick = file_q.size() - 1;
				w = file_q[pick];
				w.last_byte = 1'b1;
				file_q[pick] = w;
			end
			default: ;
		endcase

		// audio body; end marks inside it are ignored by the block
		while (file_q.size() < ITEMS - 1) begin
			w.in_byte = 8'($urandom);
			w.last_byte = ($urandom_range(0, 49) == 0);
			file_q.push_back(w);
		end
		w.in_byte = 8'($urandom);
		w.last_byte = 1'b1;
		file_q.push_back(w);

		foreach (file_q[i])
			send_byte(file_q[i]);
		src_valid <= 1'b0;

		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		int idle;
		wait (arst_n);
		forever begin
			idle = draw_wait(dst_calm);
			if (idle > 0) begin
				dst_stall <= 1'b1;
				repeat (idle) @(posedge clk);
			end
			dst_stall <= 1'b0;
			do
				@(posedge clk);
			while (!dst_valid);
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
